// ----- sv/pdf_number_token_lexer_assert.svh -----
// ---------------------------------------------------------------------------
// pdf number token lexer assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef PDF_NUMBER_TOKEN_LEXER_ASSERT_SVH
`define PDF_NUMBER_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PNTL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pntl: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PNTL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pntl: next-cycle check failed");

`endif

// ----- sv/pntl_pkg.sv -----
// ---------------------------------------------------------------------------
// pntl_pkg
// types, codes and character classes of the pdf number token lexer
// ---------------------------------------------------------------------------
package pntl_pkg;

  localparam int BYTE_W     = 8;
  localparam int IN_USER_W  = 1;
  localparam int INT_W      = 32;
  localparam int WHOLE_W    = 63;
  localparam int FRAC_W     = 60;
  localparam int CNT_W      = 5;
  localparam int OUT_DATA_W = 168;
  localparam int OUT_USER_W = 3;

  // tdata bit offsets of the result fields
  localparam int OFS_INT   = 0;
  localparam int OFS_NEG   = 32;
  localparam int OFS_WHOLE = 33;
  localparam int OFS_FRAC  = 96;
  localparam int OFS_CNT   = 156;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_INVALID  = 2'd1;
  localparam status_t ST_LIMIT    = 2'd2;
  localparam status_t ST_BAD_TERM = 2'd3;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_INT   = 3'b010,
    PH_FRAC  = 3'b100
  } phase_t;

  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  localparam logic [WHOLE_W-1:0] POS_LIMIT = 63'h0000_0000_7FFF_FFFF;
  localparam logic [WHOLE_W-1:0] NEG_LIMIT = 63'h0000_0000_8000_0000;
  localparam logic [WHOLE_W-1:0] WHOLE_SAT = {WHOLE_W{1'b1}};

  // pdf whitespace and delimiters
  function automatic logic is_terminator(input logic [BYTE_W-1:0] c);
    logic hit;
    case (c) inside
      8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20,
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h5B, 8'h5D,
      8'h7B, 8'h7D, 8'h2F, 8'h25: hit = 1'b1;
      default:                    hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- sv/pdf_number_token_lexer.sv -----
// ---------------------------------------------------------------------------
// pdf_number_token_lexer
// lexes a pdf numeric token one byte per transfer, one result per token
// ---------------------------------------------------------------------------
//  channel | dir | tdata                  | tuser
//  in_     | in  | byte_in                | end_of_input
//  out_    | out | int/neg/whole/frac/cnt | status, is_real
//
// one byte per cycle sustained while no closing byte waits on out_; a byte
// sits in the input register, where the multiply-by-ten accumulate and the close logic run
// a closing byte passes the input register, then the result register, to out_
// only a closing byte waits on the result register; other bytes never stall
// rst_n is synchronous active low and returns the lexer to start of token
// ---------------------------------------------------------------------------
module pdf_number_token_lexer #(
  parameter int MAX_FRACTION_DIGITS = 18
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pntl_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] byte_in
  input  logic [pntl_pkg::IN_USER_W-1:0]      in_tuser,   // [0] end_of_input
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] int_value, [32] negative, [95:33] whole_part,
  // [155:96] fraction_digits, [160:156] fraction_count, rest zero
  output logic [pntl_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [pntl_pkg::OUT_USER_W-1:0]     out_tuser   // [1:0] status, [2] is_real
);
  import pntl_pkg::*;

  // input register
  logic                s1_valid_r;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic                s1_eoi_r;

  // token state
  phase_t              phase_r,     phase_nxt;
  logic                minus_r,     minus_nxt;
  logic                has_whole_r, has_whole_nxt;
  logic                has_frac_r,  has_frac_nxt;
  logic [WHOLE_W-1:0]  whole_r,     whole_nxt;
  logic [FRAC_W-1:0]   frac_r,      frac_nxt;
  logic [CNT_W-1:0]    frac_len_r,  frac_len_nxt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic                is_digit;
  logic [3:0]          digit_val;
  logic                take_sign, take_point, take_wdigit, take_fdigit;
  logic                s1_close, out_free, s1_go;
  logic [WHOLE_W+4:0]  whole_x10;
  logic [FRAC_W+3:0]   frac_x10;
  logic                whole_ovf;
  logic [INT_W-1:0]    int_mag;

  status_t               res_status;
  logic                  res_real;
  logic [OUT_DATA_W-1:0] res_data;

  assign is_digit  = !s1_eoi_r && (s1_byte_r >= CH_ZERO) && (s1_byte_r <= CH_NINE);
  assign digit_val = is_digit ? s1_byte_r[3:0] : 4'd0;

  assign take_sign   = !s1_eoi_r && (phase_r == PH_START) &&
                       ((s1_byte_r == CH_PLUS) || (s1_byte_r == CH_MINUS));
  assign take_point  = !s1_eoi_r && !take_sign && (phase_r != PH_FRAC) &&
                       (s1_byte_r == CH_POINT);
  assign take_wdigit = is_digit && (phase_r != PH_FRAC);
  assign take_fdigit = is_digit && (phase_r == PH_FRAC);

  // x*10 + d as shift-add; saturate when it passes 2^63-1
  assign whole_x10 = ({5'd0, whole_r} << 3) + ({5'd0, whole_r} << 1) +
                     {{(WHOLE_W+1){1'b0}}, digit_val};
  assign whole_ovf = |whole_x10[WHOLE_W+4:WHOLE_W];
  assign frac_x10  = ({4'd0, frac_r} << 3) + ({4'd0, frac_r} << 1) +
                     {{FRAC_W{1'b0}}, digit_val};

  assign s1_close  = s1_valid_r && !(take_sign || take_point || take_wdigit || take_fdigit);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_close || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  // result of closing the token
  always_comb begin
    res_status = ST_OK;
    res_real   = 1'b0;
    res_data   = '0;
    int_mag    = minus_r ? (INT_W'(0) - whole_r[INT_W-1:0]) : whole_r[INT_W-1:0];
    if (!s1_eoi_r && !is_terminator(s1_byte_r)) begin
      res_status = ST_BAD_TERM;
    end else if (phase_r == PH_FRAC) begin
      if (!has_whole_r && !has_frac_r) begin
        res_status = ST_INVALID;
      end else begin
        res_real                           = 1'b1;
        res_data[OFS_NEG]                  = minus_r;
        res_data[OFS_WHOLE +: WHOLE_W]     = whole_r;
        res_data[OFS_FRAC +: FRAC_W]       = frac_r;
        res_data[OFS_CNT +: CNT_W]         = frac_len_r;
      end
    end else if (!has_whole_r) begin
      res_status = ST_INVALID;
    end else if (whole_r > (minus_r ? NEG_LIMIT : POS_LIMIT)) begin
      res_status = ST_LIMIT;
    end else begin
      res_data[OFS_INT +: INT_W] = int_mag;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    minus_nxt     = minus_r;
    has_whole_nxt = has_whole_r;
    has_frac_nxt  = has_frac_r;
    whole_nxt     = whole_r;
    frac_nxt      = frac_r;
    frac_len_nxt  = frac_len_r;
    if (s1_go) begin
      if (s1_close) begin
        phase_nxt     = PH_START;
        minus_nxt     = 1'b0;
        has_whole_nxt = 1'b0;
        has_frac_nxt  = 1'b0;
        whole_nxt     = '0;
        frac_nxt      = '0;
        frac_len_nxt  = '0;
      end else if (take_sign) begin
        minus_nxt = (s1_byte_r == CH_MINUS);
        phase_nxt = PH_INT;
      end else if (take_point) begin
        phase_nxt = PH_FRAC;
      end else if (take_wdigit) begin
        has_whole_nxt = 1'b1;
        whole_nxt     = whole_ovf ? WHOLE_SAT : whole_x10[WHOLE_W-1:0];
        phase_nxt     = PH_INT;
      end else begin
        has_frac_nxt = 1'b1;
        // digits past the kept count are dropped
        if (frac_len_r < CNT_W'(MAX_FRACTION_DIGITS)) begin
          frac_nxt     = frac_x10[FRAC_W-1:0];
          frac_len_nxt = frac_len_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_START;
      minus_r     <= 1'b0;
      has_whole_r <= 1'b0;
      has_frac_r  <= 1'b0;
      whole_r     <= '0;
      frac_r      <= '0;
      frac_len_r  <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_go && s1_close) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      phase_r     <= phase_nxt;
      minus_r     <= minus_nxt;
      has_whole_r <= has_whole_nxt;
      has_frac_r  <= has_frac_nxt;
      whole_r     <= whole_nxt;
      frac_r      <= frac_nxt;
      frac_len_r  <= frac_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_eoi_r  <= in_tuser[0];
    end
    if (s1_go && s1_close) begin
      out_data_r <= res_data;
      out_user_r <= {res_real, res_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- sv/pntl_checker.sv -----
// ---------------------------------------------------------------------------
// pntl_checker
// port-level checks of the pdf number token lexer result channel
// ---------------------------------------------------------------------------
`include "pdf_number_token_lexer_assert.svh"

module pntl_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [pntl_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [pntl_pkg::OUT_USER_W-1:0]     out_tuser
);
  import pntl_pkg::*;

  // a stalled result holds
  `PNTL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // an error result carries nothing but its status
  `PNTL_ASSERT_IMP(a_err_clean, out_tvalid && (out_tuser[1:0] != ST_OK), (out_tdata == '0) && !out_tuser[2])

  // an integer result uses only the int field
  `PNTL_ASSERT_IMP(a_int_clean, out_tvalid && (out_tuser[1:0] == ST_OK) && !out_tuser[2], out_tdata[OUT_DATA_W-1:INT_W] == '0)

  // a real keeps at most eighteen fraction digits and no int field
  `PNTL_ASSERT_IMP(a_real_shape, out_tvalid && out_tuser[2], (out_tdata[OFS_CNT +: CNT_W] <= 5'd18) && (out_tdata[INT_W-1:0] == '0))

endmodule

bind pdf_number_token_lexer pntl_checker u_pntl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- bench/pdf_number_token_lexer_tb.sv -----
// ---------------------------------------------------------------------------
// pdf_number_token_lexer_tb
// Drives numeric tokens into the lexer one byte per transfer. The tokens are
// mostly well formed with random signs, digits, points and closing bytes,
// mixed with boundary integers, long digit runs and raw noise. A scoreboard
// lexes every accepted byte on its own and checks each result, field by
// field, in order. Both sides insert random gaps, and the result side holds
// off for one long stretch so that the input stalls.
// ---------------------------------------------------------------------------
module pdf_number_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pntl_pkg::*;

  localparam int FRAC_KEEP  = 18;
  localparam int ITEM_COUNT = 850;

  // pdf whitespace followed by delimiters
  localparam logic [BYTE_W-1:0] CLOSERS [0:15] = '{
    8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20,
    8'h28, 8'h29, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h2F, 8'h25
  };

  typedef struct {
    status_t              status;
    logic                 is_real;
    logic [INT_W-1:0]     int_value;
    logic                 negative;
    logic [WHOLE_W-1:0]   whole;
    logic [FRAC_W-1:0]    frac_digits;
    logic [CNT_W-1:0]     frac_count;
  } token_result_t;

  class token_scoreboard;
    token_result_t        expected_tokens[$];
    phase_t               lex_phase;
    logic                 minus_seen;
    logic                 whole_seen;
    logic                 frac_seen;
    logic [WHOLE_W-1:0]   whole_acc;
    logic [FRAC_W-1:0]    frac_acc;
    logic [CNT_W-1:0]     frac_len;
    int                   bytes_taken;
    int                   tokens_checked;
    int                   failures;

    function new();
      bytes_taken    = 0;
      tokens_checked = 0;
      failures       = 0;
      restart_token();
    endfunction

    function void restart_token();
      lex_phase  = PH_START;
      minus_seen = 1'b0;
      whole_seen = 1'b0;
      frac_seen  = 1'b0;
      whole_acc  = '0;
      frac_acc   = '0;
      frac_len   = '0;
    endfunction

    function logic closes_cleanly(logic [BYTE_W-1:0] c);
      foreach (CLOSERS[i]) begin
        if (CLOSERS[i] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    // lex one accepted byte, queue a result when it closes the token
    function void note_byte(logic [BYTE_W-1:0] c, logic eoi);
      token_result_t      r;
      logic               digit;
      logic [WHOLE_W-1:0] d;
      logic [WHOLE_W-1:0] lim;
      bytes_taken++;
      digit = !eoi && c >= CH_ZERO && c <= CH_NINE;
      d     = digit ? WHOLE_W'(c - CH_ZERO) : '0;
      if (!eoi) begin
        if (lex_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
          minus_seen = (c == CH_MINUS);
          lex_phase  = PH_INT;
          return;
        end
        if (lex_phase != PH_FRAC && c == CH_POINT) begin
          lex_phase = PH_FRAC;
          return;
        end
        if (digit && lex_phase != PH_FRAC) begin
          whole_seen = 1'b1;
          if (whole_acc <= (WHOLE_SAT - d) / 63'd10) whole_acc = whole_acc * 63'd10 + d;
          else whole_acc = WHOLE_SAT;
          lex_phase = PH_INT;
          return;
        end
        if (digit) begin
          frac_seen = 1'b1;
          if (frac_len < FRAC_KEEP) begin
            frac_acc = frac_acc * 60'd10 + FRAC_W'(d);
            frac_len++;
          end
          return;
        end
      end
      r = '{status: ST_OK, is_real: 1'b0, int_value: '0, negative: 1'b0,
            whole: '0, frac_digits: '0, frac_count: '0};
      if (!eoi && !closes_cleanly(c)) begin
        r.status = ST_BAD_TERM;
      end else if (lex_phase == PH_FRAC) begin
        if (!whole_seen && !frac_seen) begin
          r.status = ST_INVALID;
        end else begin
          r.is_real     = 1'b1;
          r.negative    = minus_seen;
          r.whole       = whole_acc;
          r.frac_digits = frac_acc;
          r.frac_count  = frac_len;
        end
      end else if (!whole_seen) begin
        r.status = ST_INVALID;
      end else begin
        lim = minus_seen ? NEG_LIMIT : POS_LIMIT;
        if (whole_acc > lim) r.status = ST_LIMIT;
        else r.int_value = minus_seen ? 32'd0 - whole_acc[31:0] : whole_acc[31:0];
      end
      expected_tokens.push_back(r);
      restart_token();
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      failures++;
      if (failures <= 10) $display("mismatch %s: expected %0h actual %0h", what, want, got);
    endfunction

    function void match_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) report(what, want, got);
    endfunction

    function void check_token(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      token_result_t want;
      if (expected_tokens.size() == 0) begin
        report("unexpected result tuser", '0, 64'(user));
        return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      match_field("status", 64'(want.status), 64'(user[1:0]));
      match_field("is_real", 64'(want.is_real), 64'(user[2]));
      match_field("int_value", 64'(want.int_value), 64'(data[OFS_INT +: INT_W]));
      match_field("negative", 64'(want.negative), 64'(data[OFS_NEG]));
      match_field("whole_part", 64'(want.whole), 64'(data[OFS_WHOLE +: WHOLE_W]));
      match_field("fraction_digits", 64'(want.frac_digits), 64'(data[OFS_FRAC +: FRAC_W]));
      match_field("fraction_count", 64'(want.frac_count), 64'(data[OFS_CNT +: CNT_W]));
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;
  logic [IN_USER_W-1:0]   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [OUT_USER_W-1:0]  out_tuser;

  token_scoreboard sb;
  int              send_burst;

  pdf_number_token_lexer #(
    .MAX_FRACTION_DIGITS(FRAC_KEEP)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_item(input logic [BYTE_W-1:0] c, input logic eoi);
    int gap;
    gap = 0;
    if (send_burst > 0) begin
      send_burst--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:54]:  gap = 0;
        [55:89]: gap = $urandom_range(1, 3);
        [90:96]: gap = $urandom_range(8, 40);
        default: send_burst = $urandom_range(30, 80);
      endcase
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(c, eoi);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_random_token();
    int          kind;
    int          nw;
    int          nf;
    logic [63:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    case ($urandom_range(0, 3))
      0: send_item(CH_PLUS, 1'b0);
      1: send_item(CH_MINUS, 1'b0);
      default: ;
    endcase
    if (kind < 30) begin
      // values around the int32 edges and the saturation point
      case ($urandom_range(0, 3))
        0: v = 64'd2147483646 + 64'($urandom_range(0, 3));
        1: v = 64'h7FFF_FFFF_FFFF_FFFE + 64'($urandom_range(0, 3));
        2: v = 64'd0;
        default: v = 64'($urandom());
      endcase
      send_text($sformatf("%0d", v));
      nw = -1;
    end else begin
      nw = (kind >= 85) ? $urandom_range(15, 24) : $urandom_range(0, 6);
    end
    repeat ((nw < 0) ? 0 : nw) send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    if ($urandom_range(0, 9) < 4) begin
      send_item(CH_POINT, 1'b0);
      nf = (kind >= 85) ? $urandom_range(15, 22) : $urandom_range(0, 6);
      repeat (nf) send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end
    case ($urandom_range(0, 99)) inside
      [0:74]:  send_item(CLOSERS[$urandom_range(0, 15)], 1'b0);
      [75:86]: send_item(8'($urandom_range(0, 255)), 1'b1);
      default: send_item(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  // result side: random ready pattern with one long hold-off
  initial begin
    int stall;
    int burst;
    bit held;
    stall = 0;
    burst = 0;
    held  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_token(out_tdata, out_tuser);
      if (!held && sb.tokens_checked >= 40) begin
        held  = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:59]: out_tready <= 1'b1;
          [60:89]: begin
            out_tready <= 1'b0;
            stall = $urandom_range(0, 3);
          end
          [90:96]: begin
            out_tready <= 1'b0;
            stall = $urandom_range(10, 40);
          end
          default: begin
            out_tready <= 1'b1;
            burst = $urandom_range(20, 60);
          end
        endcase
      end
    end
  end

  initial begin
    bit paused;
    sb         = new();
    send_burst = 0;
    paused     = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty token, bare sign, sign and point, second sign
    send_item(8'h00, 1'b1);
    send_text("-.)");
    send_text("+-");
    // negative zero real closed by end of stream
    send_text("-0.0");
    send_item(8'hA5, 1'b1);
    // second point, non-delimiter closer, nul closer, fraction only
    send_text("1.2.");
    send_text("99");
    send_item(8'hFF, 1'b0);
    send_text("5");
    send_item(8'h00, 1'b0);
    send_text(".9%");
    wait_drained();

    while (sb.bytes_taken < ITEM_COUNT) begin
      if (!paused && sb.bytes_taken >= ITEM_COUNT / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      send_random_token();
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS pdf_number_token_lexer");
    end else begin
      $display("FAIL pdf_number_token_lexer");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL pdf_number_token_lexer");
    $finish;
  end

endmodule
